[sv/assert_macros.svh]
// Assertion macros used by the checker file of the watchdog timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define WDT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WDT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/wdt_pkg.sv]
// Types, constants and helper functions of the watchdog timer.
package wdt_pkg;

   typedef enum logic [2:0] {
      MODE_WRITE      = 3'd0,
      MODE_TICK       = 3'd1,
      MODE_RESTART    = 3'd2,
      MODE_FLAG_CLEAR = 3'd3,
      MODE_FLAG_SET   = 3'd4,
      MODE_IRQ_ACK    = 3'd5,
      MODE_CPU_RESET  = 3'd6,
      MODE_SYS_CYCLE  = 3'd7
   } mode_type;

   localparam int CTRL_BITS  = 8;
   localparam int WARN_BITS  = 7;
   localparam int TICKS_BITS = 21;
   localparam int WIN_BITS   = 3;
   localparam int IDX_BITS   = 4;
   localparam int BASE_SHIFT = 11;

   localparam int BIT_WDIF = 7;
   localparam int BIT_WDIE = 6;
   localparam int BIT_PS3  = 5;
   localparam int BIT_WDCE = 4;
   localparam int BIT_WDE  = 3;

   localparam logic [CTRL_BITS-1:0] PRESC_MASK = 8'h27;
   localparam logic [CTRL_BITS-1:0] CTRL_WDE   = 8'h08;

   localparam int WARN_PRESC_CLOSED = 0;
   localparam int WARN_PRESC_RSVD   = 1;
   localparam int WARN_WDE_FUSE     = 2;
   localparam int WARN_WDE_FLAG     = 3;
   localparam int WARN_WDE_CLOSED   = 4;
   localparam int WARN_WDCE_NO_WDE  = 5;
   localparam int WARN_WDIE_FUSE    = 6;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] write_data;
      logic       reset_by_watchdog;
   } item_type;

   typedef struct packed {
      logic [CTRL_BITS-1:0]  control_status;
      logic                  interrupt_request;
      logic                  reset_request;
      logic [TICKS_BITS-1:0] ticks_left;
      logic [WARN_BITS-1:0]  warnings;
   } result_type;

   function automatic logic [IDX_BITS-1:0] presc_index(input logic [CTRL_BITS-1:0] c);
      presc_index = {c[BIT_PS3], c[2:0]};
   endfunction

endpackage

[sv/wdt_if.sv]
// Channel interfaces of the watchdog timer: event input, result output, fuse write.
interface wdt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] write_data;
   logic       reset_by_watchdog;

   modport source (output valid, mode, write_data, reset_by_watchdog, input ready);
   modport sink (input valid, mode, write_data, reset_by_watchdog, output ready);
endinterface

interface wdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  control_status;
   logic        interrupt_request;
   logic        reset_request;
   logic [20:0] ticks_left;
   logic [6:0]  warnings;

   modport source (output valid, control_status, interrupt_request, reset_request,
                   ticks_left, warnings, input ready);
   modport sink (input valid, control_status, interrupt_request, reset_request,
                 ticks_left, warnings, output ready);
endinterface

interface wdt_csr_if;
   logic valid;
   logic ready;
   logic always_on_fuse;

   modport source (output valid, always_on_fuse, input ready);
   modport sink (input valid, always_on_fuse, output ready);
endinterface

[sv/watchdog_timer_control.sv]
// Top level of the watchdog timer with timed change-enable control byte.
//
// Usage: every event word arrives on req_ch (mode, write_data, reset_by_watchdog)
// and yields exactly one result word on rsp_ch: the control byte after the event,
// the interrupt request, a one-word reset request pulse, the ticks left to the
// next timeout and a warning mask for refused or reserved writes.
// The fuse is written on csr_ch, which is always ready; it should only be
// written while no event is in flight.
// An accepted event is held in the input register; the update logic then feeds the
// result register, from which the word leaves on rsp_ch. Throughput is one word
// per cycle while rsp_ch takes every word, as the state update is combinational.
// When rsp_ch stalls, the result register holds its word and the input register
// still takes one more word; req_ch.ready falls only when both are full.
// Reset clears the control byte, counter, reset flag, change window and fuse,
// and empties both registers.
module watchdog_timer_control #(
   parameter int COUNTER_BITS  = 20,
   parameter int MAX_INDEX     = 9,
   parameter int CHANGE_CYCLES = 4
) (
   input logic      clock,
   input logic      reset,
   wdt_req_if.sink  req_ch,
   wdt_rsp_if.source rsp_ch,
   wdt_csr_if.sink  csr_ch
);
   import wdt_pkg::*;

   item_type   item;
   logic       item_valid;
   logic       take;
   result_type result;

   assign csr_ch.ready = 1'b1;

   wdt_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   wdt_core #(
      .COUNTER_BITS  (COUNTER_BITS),
      .MAX_INDEX     (MAX_INDEX),
      .CHANGE_CYCLES (CHANGE_CYCLES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .item_valid   (item_valid),
      .take         (take),
      .csr_write    (csr_ch.valid),
      .csr_fuse     (csr_ch.always_on_fuse),
      .result       (result),
      .result_valid (rsp_ch.valid),
      .result_ready (rsp_ch.ready)
   );

   assign rsp_ch.control_status    = result.control_status;
   assign rsp_ch.interrupt_request = result.interrupt_request;
   assign rsp_ch.reset_request     = result.reset_request;
   assign rsp_ch.ticks_left        = result.ticks_left;
   assign rsp_ch.warnings          = result.warnings;

endmodule

[sv/wdt_in_stage.sv]
// Input register of the watchdog timer: holds one accepted event word.
module wdt_in_stage (
   input  logic               clock,
   input  logic               reset,
   wdt_req_if.sink            req,
   input  logic               take,
   output wdt_pkg::item_type  item,
   output logic               item_valid
);
   import wdt_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req.ready  = !valid_ff || take;
   assign accept     = req.valid && req.ready;
   assign item       = item_ff;
   assign item_valid = valid_ff;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.mode              <= mode_type'(req.mode);
         item_ff.write_data        <= req.write_data;
         item_ff.reset_by_watchdog <= req.reset_by_watchdog;
      end
   end

endmodule

[sv/wdt_core.sv]
// Watchdog state, the per-event update logic and the result register.
module wdt_core #(
   parameter int COUNTER_BITS  = 20,
   parameter int MAX_INDEX     = 9,
   parameter int CHANGE_CYCLES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  wdt_pkg::item_type   item,
   input  logic                item_valid,
   output logic                take,
   input  logic                csr_write,
   input  logic                csr_fuse,
   output wdt_pkg::result_type result,
   output logic                result_valid,
   input  logic                result_ready
);
   import wdt_pkg::*;

   localparam int PER_BITS = BASE_SHIFT + MAX_INDEX + 1;
   localparam int WW0 = (COUNTER_BITS > PER_BITS) ? COUNTER_BITS : PER_BITS;
   localparam int WW  = (WW0 > TICKS_BITS) ? WW0 : TICKS_BITS;
   localparam logic [IDX_BITS-1:0] MAX_IDX = IDX_BITS'(MAX_INDEX);
   localparam logic [WIN_BITS-1:0] WIN_LOAD = WIN_BITS'(CHANGE_CYCLES);

   logic [CTRL_BITS-1:0]    ctrl_ff, ctrl_in;
   logic [COUNTER_BITS-1:0] cnt_ff, cnt_in;
   logic                    flag_ff, flag_in;
   logic [WIN_BITS-1:0]     win_ff, win_in;
   logic                    fuse_ff;
   result_type              result_ff, result_in;
   logic                    valid_ff, valid_in;

   function automatic logic [WW-1:0] period_of(input logic [CTRL_BITS-1:0] c);
      logic [IDX_BITS-1:0] idx;
      idx = presc_index(c);
      if (idx > MAX_IDX) begin
         period_of = '0;
      end else begin
         period_of = WW'(1) << (BASE_SHIFT + int'(idx));
      end
   endfunction

   assign take         = item_valid && (!valid_ff || result_ready);
   assign result       = result_ff;
   assign result_valid = valid_ff;

   always_comb begin
      logic [CTRL_BITS-1:0] c;
      logic [7:0]           d;
      logic                 ce_open;
      logic [WARN_BITS-1:0] w;
      logic                 rst;
      logic [WW-1:0]        per_t, per_f, cnt_w, left;

      c       = ctrl_ff;
      d       = item.write_data;
      ce_open = ctrl_ff[BIT_WDCE];
      w       = '0;
      rst     = 1'b0;
      cnt_in  = cnt_ff;
      flag_in = flag_ff;
      win_in  = win_ff;
      per_t   = '0;

      unique case (item.mode)
         MODE_WRITE: begin
            if (presc_index(d) != presc_index(c)) begin
               if (!ce_open) begin
                  w[WARN_PRESC_CLOSED] = 1'b1;
               end else begin
                  c = (c & ~PRESC_MASK) | (d & PRESC_MASK);
                  if (presc_index(d) > MAX_IDX) begin
                     w[WARN_PRESC_RSVD] = 1'b1;
                  end
               end
            end
            if (!d[BIT_WDE] && c[BIT_WDE]) begin
               priority if (fuse_ff) begin
                  w[WARN_WDE_FUSE] = 1'b1;
               end else if (flag_ff) begin
                  w[WARN_WDE_FLAG] = 1'b1;
               end else if (!ce_open) begin
                  w[WARN_WDE_CLOSED] = 1'b1;
               end else begin
                  c[BIT_WDE] = 1'b0;
               end
            end else if (!fuse_ff) begin
               c[BIT_WDE] = d[BIT_WDE];
            end
            if (d[BIT_WDCE] && !c[BIT_WDCE]) begin
               if (d[BIT_WDE]) begin
                  c[BIT_WDCE] = 1'b1;
                  win_in      = WIN_LOAD;
               end else begin
                  w[WARN_WDCE_NO_WDE] = 1'b1;
               end
            end else if (!d[BIT_WDCE]) begin
               c[BIT_WDCE] = 1'b0;
               win_in      = '0;
            end
            if (d[BIT_WDIE] && fuse_ff) begin
               w[WARN_WDIE_FUSE] = 1'b1;
            end else if (!fuse_ff) begin
               c[BIT_WDIE] = d[BIT_WDIE];
            end
            if (d[BIT_WDIF]) begin
               c[BIT_WDIF] = 1'b0;
            end
         end
         MODE_TICK: begin
            if (c[BIT_WDE] || c[BIT_WDIE]) begin
               cnt_in = cnt_ff + COUNTER_BITS'(1);
               per_t  = period_of(c);
               if (per_t != '0 && (WW'(cnt_in) & (per_t - WW'(1))) == '0) begin
                  if (c[BIT_WDIE]) begin
                     c[BIT_WDIF] = 1'b1;
                  end else begin
                     rst = 1'b1;
                  end
               end
            end
         end
         MODE_RESTART: begin
            cnt_in = '0;
         end
         MODE_FLAG_CLEAR: begin
            flag_in = 1'b0;
         end
         MODE_FLAG_SET: begin
            flag_in    = 1'b1;
            c[BIT_WDE] = 1'b1;
         end
         MODE_IRQ_ACK: begin
            c[BIT_WDIF] = 1'b0;
            if (c[BIT_WDE]) begin
               c[BIT_WDIE] = 1'b0;
            end
         end
         MODE_CPU_RESET: begin
            if (item.reset_by_watchdog) begin
               flag_in = 1'b1;
            end
            c      = (fuse_ff || flag_in) ? CTRL_WDE : '0;
            win_in = '0;
         end
         MODE_SYS_CYCLE: begin
            if (win_ff != '0) begin
               win_in = win_ff - WIN_BITS'(1);
               if (win_in == '0) begin
                  c[BIT_WDCE] = 1'b0;
               end
            end
         end
         default: begin
            c = ctrl_ff;
         end
      endcase

      ctrl_in = c;
      per_f   = period_of(c);
      cnt_w   = WW'(cnt_in);
      left    = (per_f == '0) ? '0 : per_f - (cnt_w & (per_f - WW'(1)));

      result_in.control_status    = c;
      result_in.interrupt_request = c[BIT_WDIF] && c[BIT_WDIE];
      result_in.reset_request     = rst;
      result_in.ticks_left        = left[TICKS_BITS-1:0];
      result_in.warnings          = w;
   end

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (result_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         cnt_ff   <= '0;
         flag_ff  <= 1'b0;
         win_ff   <= '0;
         fuse_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_write) begin
            fuse_ff <= csr_fuse;
            if (csr_fuse) begin
               ctrl_ff <= (ctrl_ff | CTRL_WDE) & ~(CTRL_BITS'(1) << BIT_WDIE);
            end
         end else if (take) begin
            ctrl_ff <= ctrl_in;
            cnt_ff  <= cnt_in;
            flag_ff <= flag_in;
            win_ff  <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

[sv/wdt_checker.sv]
// Port-level checker of the watchdog timer and its bind to the top level.
`include "assert_macros.svh"

module wdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  control_status,
   input logic        interrupt_request,
   input logic        reset_request,
   input logic [20:0] ticks_left,
   input logic [6:0]  warnings
);
   import wdt_pkg::*;

   `WDT_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(control_status)
         && $stable(ticks_left) && $stable(warnings),
      "Stalled result word changed or dropped.")
   `WDT_ASSERT(a_irq_bits,
      rsp_valid && interrupt_request |-> control_status[BIT_WDIF] && control_status[BIT_WDIE],
      "Interrupt request without flag and enable.")
   `WDT_ASSERT(a_rst_mode,
      rsp_valid && reset_request |-> control_status[BIT_WDE] && !control_status[BIT_WDIE]
         && warnings == '0,
      "Reset request outside reset-only mode.")
   `WDT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "Result word valid straight after reset.")

endmodule

bind watchdog_timer_control wdt_checker u_wdt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .control_status    (rsp_ch.control_status),
   .interrupt_request (rsp_ch.interrupt_request),
   .reset_request     (rsp_ch.reset_request),
   .ticks_left        (rsp_ch.ticks_left),
   .warnings          (rsp_ch.warnings)
);
